// ----- design/ggrm_pkg.sv -----
// Package for the gray-to-glyph run mapper: payload structs, register
// indexes, the Q0.16 density threshold table and the glyph ramp.
// Depends on nothing; every design file imports it.
package ggrm_pkg;

    // Field widths fixed by the interface.
    localparam int LEVEL_W = 8;
    localparam int RANK_W  = 7;
    localparam int CODE_W  = 7;
    localparam int THR_W   = 16;
    localparam int PROD_W  = THR_W + LEVEL_W;

    // Number of thresholds and glyphs in the constant tables.
    localparam int THR_LEN = 92;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_EN  = 2'd3;

    // One input pixel.
    typedef struct packed {
        logic [LEVEL_W-1:0] gray_level;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic               frame_start;
        logic               row_end;
    } t_ggrm_in;

    // One output glyph.
    typedef struct packed {
        logic [CODE_W-1:0]  glyph_code;
        logic [RANK_W-1:0]  glyph_rank;
        logic               run_start;
        logic [LEVEL_W-1:0] run_red;
        logic [LEVEL_W-1:0] run_green;
        logic [LEVEL_W-1:0] run_blue;
        logic               line_end;
    } t_ggrm_out;

    // Nondecreasing density thresholds, each round(t * 65536).
    localparam logic [THR_W-1:0] THR_Q16 [THR_LEN] = '{
        16'd0,     16'd4922,  16'd5433,  16'd5557,  16'd8041,  16'd9195,
        16'd10217, 16'd12124, 16'd14307, 16'd15840, 16'd16849, 16'd18691,
        16'd19019, 16'd19130, 16'd20310, 16'd20919, 16'd21181, 16'd21588,
        16'd22177, 16'd23652, 16'd23717, 16'd24032, 16'd24491, 16'd24556,
        16'd25153, 16'd25697, 16'd25952, 16'd26110, 16'd26169, 16'd26706,
        16'd26811, 16'd26876, 16'd27525, 16'd27722, 16'd27833, 16'd28010,
        16'd28135, 16'd28364, 16'd28718, 16'd28738, 16'd28967, 16'd29314,
        16'd29340, 16'd29511, 16'd29898, 16'd30015, 16'd30212, 16'd30396,
        16'd30586, 16'd30710, 16'd30756, 16'd30822, 16'd31674, 16'd31988,
        16'd32401, 16'd32460, 16'd32716, 16'd36104, 16'd36484, 16'd36497,
        16'd36641, 16'd36713, 16'd36713, 16'd37028, 16'd37854, 16'd37860,
        16'd38129, 16'd38470, 16'd39138, 16'd39315, 16'd39603, 16'd39643,
        16'd39931, 16'd39970, 16'd42369, 16'd42998, 16'd43221, 16'd43457,
        16'd44001, 16'd44296, 16'd44623, 16'd44669, 16'd45384, 16'd46131,
        16'd46439, 16'd47415, 16'd47854, 16'd48051, 16'd49820, 16'd51341,
        16'd52671, 16'd65529
    };

    // Glyph ramp from sparse to dense; character 0 sits in the top byte.
    localparam logic [8*THR_LEN-1:0] GLYPH_RAMP = {
        " `.-':_,^=;><+!rc*/",
        "z?sLTv)J7(|Fi{C}fI31tlu[neoZ5Yxjya]",
        "2ESwqkP6h9d4VpOGbUAKXHm8RD#$Bg0MNWQ%&@"
    };

    // ASCII code of the glyph at a given density rank.
    function automatic logic [CODE_W-1:0] glyph_of(input logic [RANK_W-1:0] rank);
        int pos;
        pos = 8 * (THR_LEN - 1 - int'(rank));
        return GLYPH_RAMP[pos +: CODE_W];
    endfunction

endpackage

// ----- design/gray_to_glyph_run_mapper.sv -----
// Gray-to-glyph run mapper: ranks each pixel's gray level against the density
// thresholds and reuses the previous glyph while brightness stays in tolerance.
// A request passes the stage-1, stage-2 and output registers in turn; one
// request is accepted every cycle, limited only by the output stall.
// Reset (synchronous, active low) empties the pipeline, clears the run state
// and loads the register reset values.
module gray_to_glyph_run_mapper
    import ggrm_pkg::*;
#(
    parameter int RAMP_SIZE = 92
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Pixel request channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_ggrm_in             i_in_data,
    // Glyph result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_ggrm_out            o_out_data,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEVEL_W-1:0]   i_cfg_data
);

    // Glyphs in use: the ramp cannot exceed the threshold table.
    localparam int NUM_GLYPH = (RAMP_SIZE < THR_LEN) ? RAMP_SIZE : THR_LEN;
    localparam int MASK_W    = 2 ** RANK_W;

    // Configuration registers.
    logic [LEVEL_W-1:0] r_min_level;
    logic [LEVEL_W-1:0] r_max_level;
    logic [LEVEL_W-1:0] r_tolerance;
    logic               r_color_en;

    // Pipeline registers.
    logic               r_s1_valid;
    t_ggrm_in           r_s1_data;
    logic               r_s2_valid;
    t_ggrm_in           r_s2_data;
    logic [MASK_W-1:0]  r_s2_mask;
    logic               r_out_valid;
    t_ggrm_out          r_out_data;

    // Run state.
    logic [LEVEL_W-1:0] r_kept_bright;
    logic [RANK_W-1:0]  r_kept_rank;
    logic [LEVEL_W-1:0] r_kept_red;
    logic [LEVEL_W-1:0] r_kept_green;
    logic [LEVEL_W-1:0] r_kept_blue;

    logic               out_ready;
    logic               s2_ready;
    logic               s1_ready;

    logic [MASK_W-1:0]  n_mask;
    logic [RANK_W-1:0]  n_rank;
    logic [LEVEL_W-1:0] n_kept_bright;
    logic [RANK_W-1:0]  n_kept_rank;
    logic [LEVEL_W-1:0] n_kept_red;
    logic [LEVEL_W-1:0] n_kept_green;
    logic [LEVEL_W-1:0] n_kept_blue;
    logic               n_run_start;

    // Each stage moves on when the stage after it has room.
    assign out_ready   = !r_out_valid || !i_out_stall;
    assign s2_ready    = !r_s2_valid || out_ready;
    assign s1_ready    = !r_s1_valid || s2_ready;
    assign o_in_stall  = !s1_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_level <= '0;
            r_max_level <= '1;
            r_tolerance <= LEVEL_W'(15);
            r_color_en  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_LEVEL: r_min_level <= i_cfg_data;
                CFG_MAX_LEVEL: r_max_level <= i_cfg_data;
                CFG_TOLERANCE: r_tolerance <= i_cfg_data;
                CFG_COLOR_EN:  r_color_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Threshold compare: mark every rank whose scaled threshold does not
    // exceed the offset gray level. A flat frame or a pixel at or below the
    // minimum leaves the mask empty, which later gives rank zero.
    always_comb begin
        logic [LEVEL_W-1:0] gray_clip;
        logic [LEVEL_W-1:0] span;
        logic [PROD_W-1:0]  num;
        logic [PROD_W-1:0]  prod;
        logic               rank_zero;
        gray_clip = (r_s1_data.gray_level > r_max_level) ? r_max_level
                                                         : r_s1_data.gray_level;
        span      = r_max_level - r_min_level;
        num       = {gray_clip - r_min_level, {THR_W{1'b0}}};
        rank_zero = (r_max_level <= r_min_level) ||
                    (r_s1_data.gray_level <= r_min_level);
        n_mask    = '0;
        for (int i = 0; i < NUM_GLYPH; i++) begin
            prod      = PROD_W'({{LEVEL_W{1'b0}}, THR_Q16[i]} *
                                {{THR_W{1'b0}}, span});
            n_mask[i] = !rank_zero && (prod <= num);
        end
    end

    // Rank search: the mask is a thermometer code, so a binary search over
    // its bits finds the highest set position in one step per rank bit.
    always_comb begin
        logic [RANK_W-1:0] cand;
        n_rank = '0;
        for (int b = RANK_W - 1; b >= 0; b--) begin
            cand = n_rank | RANK_W'(1 << b);
            if (r_s2_mask[cand]) begin
                n_rank = cand;
            end
        end
    end

    // Run decision: a frame start clears the kept run first; the pixel
    // continues the run if its brightness stays within tolerance.
    always_comb begin
        logic [LEVEL_W-1:0] base_bright;
        logic [LEVEL_W-1:0] diff;
        if (r_s2_data.frame_start) begin
            base_bright  = '0;
            n_kept_rank  = '0;
            n_kept_red   = '0;
            n_kept_green = '0;
            n_kept_blue  = '0;
        end else begin
            base_bright  = r_kept_bright;
            n_kept_rank  = r_kept_rank;
            n_kept_red   = r_kept_red;
            n_kept_green = r_kept_green;
            n_kept_blue  = r_kept_blue;
        end
        n_kept_bright = base_bright;
        diff = (r_s2_data.gray_level >= base_bright) ?
               (r_s2_data.gray_level - base_bright) :
               (base_bright - r_s2_data.gray_level);
        n_run_start = !(diff < r_tolerance);
        if (n_run_start) begin
            n_kept_bright = r_s2_data.gray_level;
            n_kept_rank   = n_rank;
            n_kept_red    = r_s2_data.red_level;
            n_kept_green  = r_s2_data.green_level;
            n_kept_blue   = r_s2_data.blue_level;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_data <= r_s1_data;
            r_s2_mask <= n_mask;
        end
        if (out_ready && r_s2_valid) begin
            r_out_data.glyph_code <= glyph_of(n_kept_rank);
            r_out_data.glyph_rank <= n_kept_rank;
            r_out_data.run_start  <= n_run_start;
            r_out_data.run_red    <= r_color_en ? n_kept_red   : '0;
            r_out_data.run_green  <= r_color_en ? n_kept_green : '0;
            r_out_data.run_blue   <= r_color_en ? n_kept_blue  : '0;
            r_out_data.line_end   <= r_s2_data.row_end;
        end
    end

    // Run state advances once per pixel handed to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept_bright <= '0;
            r_kept_rank   <= '0;
            r_kept_red    <= '0;
            r_kept_green  <= '0;
            r_kept_blue   <= '0;
        end else if (out_ready && r_s2_valid) begin
            r_kept_bright <= n_kept_bright;
            r_kept_rank   <= n_kept_rank;
            r_kept_red    <= n_kept_red;
            r_kept_green  <= n_kept_green;
            r_kept_blue   <= n_kept_blue;
        end
    end

endmodule
